// ===== src/kmfp_pkg.sv =====
package kmfp_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 8;
  localparam int PLY_W  = 7;
  localparam int SEG_W  = 9;
  localparam int PC_W   = 3;
  localparam int SQ_W   = 7;
  localparam int KIND_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SAVE   = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SAVE,
    S_KREAD,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_e;

  // list read address select
  typedef enum logic [2:0] {
    RA_INDEX,
    RA_START,
    RA_NEXT,
    RA_PREV,
    RA_PREV2
  } rsel_e;

  // list write source, which also fixes the write address
  typedef enum logic [1:0] {
    WS_ITEM,
    WS_SHIFT,
    WS_HELD
  } wsrc_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_START,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef struct packed {
    logic [PC_W-1:0]   piece;
    logic [PC_W-1:0]   captured;
    logic [SQ_W-1:0]   from_sq;
    logic [SQ_W-1:0]   to_sq;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic [SQ_W-1:0] from_sq;
    logic [SQ_W-1:0] to_sq;
  } kpair_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  index;
    logic [PLY_W-1:0]  ply;
    logic [IDX_W-1:0]  start_req;
    logic [SEG_W-1:0]  segment_end;
    logic [PC_W-1:0]   piece;
    logic [PC_W-1:0]   captured;
    logic [SQ_W-1:0]   from_sq;
    logic [SQ_W-1:0]   to_sq;
    logic [KIND_W-1:0] move_kind;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic [PC_W-1:0]   out_piece;
    logic [PC_W-1:0]   out_captured;
    logic [SQ_W-1:0]   out_from;
    logic [SQ_W-1:0]   out_to;
    logic [KIND_W-1:0] out_kind;
  } res_t;

  typedef struct packed {
    logic    load_item;
    logic    list_rd;
    rsel_e   rsel;
    logic    list_wr;
    wsrc_e   wsrc;
    logic    kill_rd;
    logic    kill_wr;
    logic    kill_clear;
    ptr_op_e ptr_op;
    logic    res_hit;
    logic    load_out;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic index_ok;
    logic ply_ok;
    logic seg_ok;
    logic hit;
    logic last_scan;
    logic at_start;
    logic prev_is_start;
    logic clr_last;
  } stat_t;

endpackage

// ===== src/kmfp_if.sv =====
interface kmfp_in_if;
  import kmfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  index;
  logic [PLY_W-1:0]  ply;
  logic [IDX_W-1:0]  start_req;
  logic [SEG_W-1:0]  segment_end;
  logic [PC_W-1:0]   piece;
  logic [PC_W-1:0]   captured;
  logic [SQ_W-1:0]   from_sq;
  logic [SQ_W-1:0]   to_sq;
  logic [KIND_W-1:0] move_kind;

  modport source (
    output valid, cmd, index, ply, start_req, segment_end,
           piece, captured, from_sq, to_sq, move_kind,
    input  ready
  );

  modport sink (
    input  valid, cmd, index, ply, start_req, segment_end,
           piece, captured, from_sq, to_sq, move_kind,
    output ready
  );
endinterface

interface kmfp_out_if;
  import kmfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  found_index;
  logic [PC_W-1:0]   out_piece;
  logic [PC_W-1:0]   out_captured;
  logic [SQ_W-1:0]   out_from;
  logic [SQ_W-1:0]   out_to;
  logic [KIND_W-1:0] out_kind;

  modport source (
    output valid, found, found_index, out_piece, out_captured, out_from, out_to, out_kind,
    input  ready
  );

  modport sink (
    input  valid, found, found_index, out_piece, out_captured, out_from, out_to, out_kind,
    output ready
  );
endinterface

// ===== src/kmfp_ctrl.sv =====
module kmfp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  kmfp_pkg::stat_t st_i,
  output kmfp_pkg::ctrl_t ctl_o
);
  import kmfp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    ctl_o.load_item  = 1'b0;
    ctl_o.list_rd    = 1'b0;
    ctl_o.rsel       = RA_INDEX;
    ctl_o.list_wr    = 1'b0;
    ctl_o.wsrc       = WS_ITEM;
    ctl_o.kill_rd    = 1'b0;
    ctl_o.kill_wr    = 1'b0;
    ctl_o.kill_clear = 1'b0;
    ctl_o.ptr_op     = PTR_HOLD;
    ctl_o.res_hit    = 1'b0;
    ctl_o.load_out   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ctl_o.kill_wr    = 1'b1;
        ctl_o.kill_clear = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (st_i.cmd)
          CMD_WRITE: begin
            ctl_o.list_wr = st_i.index_ok;
            ctl_o.wsrc    = WS_ITEM;
          end
          CMD_READ: begin
            ctl_o.list_rd = st_i.index_ok;
            ctl_o.rsel    = RA_INDEX;
          end
          CMD_SAVE: begin
            if (st_i.index_ok && st_i.ply_ok) begin
              ctl_o.list_rd = 1'b1;
              ctl_o.rsel    = RA_INDEX;
              state_d       = S_SAVE;
            end
          end
          CMD_INSERT: begin
            if (st_i.ply_ok && st_i.seg_ok) begin
              ctl_o.kill_rd = 1'b1;
              state_d       = S_KREAD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SAVE: begin
        ctl_o.kill_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_KREAD: begin
        ctl_o.list_rd = 1'b1;
        ctl_o.rsel    = RA_START;
        ctl_o.ptr_op  = PTR_START;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        // read data belongs to the pointer, the next address is fetched ahead
        if (st_i.hit) begin
          ctl_o.res_hit = 1'b1;
          if (st_i.at_start) begin
            state_d = S_PLACE;
          end else begin
            ctl_o.list_rd = 1'b1;
            ctl_o.rsel    = RA_PREV;
            state_d       = S_SHIFT;
          end
        end else if (st_i.last_scan) begin
          state_d = S_DONE;
        end else begin
          ctl_o.list_rd = 1'b1;
          ctl_o.rsel    = RA_NEXT;
          ctl_o.ptr_op  = PTR_INC;
        end
      end
      S_SHIFT: begin
        // entry below the pointer moves up one place
        ctl_o.list_wr = 1'b1;
        ctl_o.wsrc    = WS_SHIFT;
        if (st_i.prev_is_start) begin
          state_d = S_PLACE;
        end else begin
          ctl_o.list_rd = 1'b1;
          ctl_o.rsel    = RA_PREV2;
          ctl_o.ptr_op  = PTR_DEC;
        end
      end
      S_PLACE: begin
        ctl_o.list_wr = 1'b1;
        ctl_o.wsrc    = WS_HELD;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase

    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EXEC)
    else $error("accepted transaction did not start execution");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");

endmodule

// ===== src/kmfp_dp.sv =====
module kmfp_dp #(
  parameter int PLY_SLOTS    = 128,
  parameter int LIST_ENTRIES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kmfp_pkg::item_t item_i,
  input  kmfp_pkg::ctrl_t ctl_i,
  output kmfp_pkg::stat_t st_o,
  output kmfp_pkg::res_t  res_o
);
  import kmfp_pkg::*;

  localparam int LA = $clog2(LIST_ENTRIES);
  localparam int CW = (LA + 1 > SEG_W) ? LA + 1 : SEG_W;
  localparam int PA = $clog2(PLY_SLOTS);
  localparam int PW = (PA + 1 > PLY_W) ? PA + 1 : PLY_W;

  entry_t list_mem [LIST_ENTRIES];
  kpair_t kill_mem [PLY_SLOTS];

  cmd_e          cmd_q;
  logic [CW-1:0] index_q;
  logic [PW-1:0] ply_q;
  logic [CW-1:0] start_q;
  logic [CW-1:0] end_q;
  entry_t        entry_q;

  entry_t        rdata_q;
  kpair_t        kill_q;
  entry_t        held_q;
  logic [IDX_W-1:0] fidx_q;
  res_t          res_q;

  logic [CW-1:0] ptr_q, ptr_d;
  logic [PA-1:0] clr_cnt_q;
  logic          found_q;

  logic [CW-1:0] seg_ext;
  logic [CW-1:0] seg_clip;
  logic [CW-1:0] raddr;
  logic [CW-1:0] waddr;
  entry_t        wdata;
  logic [PA-1:0] kaddr;
  kpair_t        kdata;
  logic          rd_ok;

  assign seg_ext  = CW'(item_i.segment_end);
  assign seg_clip = (seg_ext > CW'(LIST_ENTRIES)) ? CW'(LIST_ENTRIES) : seg_ext;

  // latched transaction
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q            <= cmd_e'(item_i.cmd);
      index_q          <= CW'(item_i.index);
      ply_q            <= PW'(item_i.ply);
      start_q          <= CW'(item_i.start_req);
      end_q            <= seg_clip;
      entry_q.piece    <= item_i.piece;
      entry_q.captured <= item_i.captured;
      entry_q.from_sq  <= item_i.from_sq;
      entry_q.to_sq    <= item_i.to_sq;
      entry_q.kind     <= item_i.move_kind;
    end
  end

  always_comb begin
    unique case (ctl_i.rsel)
      RA_INDEX: raddr = index_q;
      RA_START: raddr = start_q;
      RA_NEXT:  raddr = ptr_q + CW'(1);
      RA_PREV:  raddr = ptr_q - CW'(1);
      RA_PREV2: raddr = ptr_q - CW'(2);
      default:  raddr = index_q;
    endcase

    unique case (ctl_i.wsrc)
      WS_ITEM: begin
        waddr = index_q;
        wdata = entry_q;
      end
      WS_SHIFT: begin
        waddr = ptr_q;
        wdata = rdata_q;
      end
      WS_HELD: begin
        waddr = start_q;
        wdata = held_q;
      end
      default: begin
        waddr = index_q;
        wdata = entry_q;
      end
    endcase

    if (ctl_i.kill_clear) begin
      kaddr = clr_cnt_q;
      kdata = '0;
    end else begin
      kaddr         = ply_q[PA-1:0];
      kdata.from_sq = rdata_q.from_sq;
      kdata.to_sq   = rdata_q.to_sq;
    end

    unique case (ctl_i.ptr_op)
      PTR_HOLD:  ptr_d = ptr_q;
      PTR_START: ptr_d = start_q;
      PTR_INC:   ptr_d = ptr_q + CW'(1);
      PTR_DEC:   ptr_d = ptr_q - CW'(1);
      default:   ptr_d = ptr_q;
    endcase
  end

  // move list memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.list_wr) list_mem[waddr[LA-1:0]] <= wdata;
    if (ctl_i.list_rd) rdata_q <= list_mem[raddr[LA-1:0]];
  end

  // killer table memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.kill_wr) kill_mem[kaddr] <= kdata;
    if (ctl_i.kill_rd) kill_q <= kill_mem[ply_q[PA-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      clr_cnt_q <= '0;
      found_q   <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (ctl_i.kill_clear) clr_cnt_q <= clr_cnt_q + PA'(1);
      if (ctl_i.load_item) begin
        found_q <= 1'b0;
      end else if (ctl_i.res_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      fidx_q <= '0;
    end else if (ctl_i.res_hit) begin
      fidx_q <= ptr_q[IDX_W-1:0];
      held_q <= rdata_q;
    end
  end

  assign rd_ok = (cmd_q == CMD_READ) && st_o.index_ok;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      res_q.found        <= found_q;
      res_q.found_index  <= fidx_q;
      res_q.out_piece    <= rd_ok ? rdata_q.piece    : '0;
      res_q.out_captured <= rd_ok ? rdata_q.captured : '0;
      res_q.out_from     <= rd_ok ? rdata_q.from_sq  : '0;
      res_q.out_to       <= rd_ok ? rdata_q.to_sq    : '0;
      res_q.out_kind     <= rd_ok ? rdata_q.kind     : '0;
    end
  end

  assign res_o = res_q;

  assign st_o.cmd           = cmd_q;
  assign st_o.index_ok      = index_q < CW'(LIST_ENTRIES);
  assign st_o.ply_ok        = ply_q < PW'(PLY_SLOTS);
  assign st_o.seg_ok        = start_q < end_q;
  assign st_o.hit           = (rdata_q.from_sq == kill_q.from_sq) &&
                              (rdata_q.to_sq == kill_q.to_sq);
  assign st_o.last_scan     = (ptr_q + CW'(1)) == end_q;
  assign st_o.at_start      = ptr_q == start_q;
  assign st_o.prev_is_start = (ptr_q - CW'(1)) == start_q;
  assign st_o.clr_last      = clr_cnt_q == PA'(PLY_SLOTS - 1);

  a_shift_above_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.list_wr && ctl_i.wsrc == WS_SHIFT |-> ptr_q > start_q)
    else $error("shift write at or below segment start");

  a_scan_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.ptr_op == PTR_INC |-> (ptr_q + CW'(1)) < end_q)
    else $error("search pointer left the segment");

endmodule

// ===== src/killer_move_front_promoter_top.sv =====
// Killer-move front promoter: keeps a move list memory and a per-ply killer table and serves
// one command per transaction (write entry, read entry, save killer, insert killer), each
// answered by exactly one result. After reset the killer table is cleared one slot per cycle,
// so no transaction is taken until every slot is cleared. Insert reads the killer, then walks
// the segment at one list entry per cycle through the single read port of the list memory,
// and on a hit moves the entries between up one place through the single write port, one per
// cycle, and writes the killer at the segment start. A new transaction is accepted while the
// previous result waits on the output register.
module killer_move_front_promoter_top #(
  parameter int PLY_SLOTS    = 128,
  parameter int LIST_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kmfp_in_if.sink           in_i,
  kmfp_out_if.source        out_o
);
  import kmfp_pkg::*;

  item_t item;
  res_t  res;
  ctrl_t ctl;
  stat_t st;

  assign item.cmd         = in_i.cmd;
  assign item.index       = in_i.index;
  assign item.ply         = in_i.ply;
  assign item.start_req   = in_i.start_req;
  assign item.segment_end = in_i.segment_end;
  assign item.piece       = in_i.piece;
  assign item.captured    = in_i.captured;
  assign item.from_sq     = in_i.from_sq;
  assign item.to_sq       = in_i.to_sq;
  assign item.move_kind   = in_i.move_kind;

  kmfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .ctl_o       (ctl)
  );

  kmfp_dp #(
    .PLY_SLOTS    (PLY_SLOTS),
    .LIST_ENTRIES (LIST_ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .ctl_i  (ctl),
    .st_o   (st),
    .res_o  (res)
  );

  assign out_o.found        = res.found;
  assign out_o.found_index  = res.found_index;
  assign out_o.out_piece    = res.out_piece;
  assign out_o.out_captured = res.out_captured;
  assign out_o.out_from     = res.out_from;
  assign out_o.out_to       = res.out_to;
  assign out_o.out_kind     = res.out_kind;

endmodule

// ===== tb/killer_move_front_promoter_top_tb.sv =====
module killer_move_front_promoter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmfp_pkg::*;

  localparam int PLY_SLOTS      = 128;
  localparam int LIST_ENTRIES   = 256;
  localparam int RANDOM_CMDS    = 80;
  localparam int PRESSURE_ITEMS = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2500;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  kmfp_in_if  in_if ();
  kmfp_out_if out_if ();

  killer_move_front_promoter_top #(
    .PLY_SLOTS   (PLY_SLOTS),
    .LIST_ENTRIES(LIST_ENTRIES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the list memory and the killer table
  entry_t move_list_m [LIST_ENTRIES];
  kpair_t killer_m [PLY_SLOTS];
  kpair_t pair_pool [6];

  res_t pending_results [$];

  int  n_errors = 0;
  int  n_per_cmd [4] = '{0, 0, 0, 0};
  int  n_hits = 0;
  int  quiet_cycles = 0;
  int  hold_request = 0;
  bit  rx_holding = 1'b0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  function automatic res_t apply_command(item_t it);
    res_t   r;
    int     stop;
    int     pos;
    int     k;
    entry_t held;
    r = '0;
    case (it.cmd)
      CMD_WRITE: begin
        move_list_m[it.index] = '{piece: it.piece, captured: it.captured,
                                  from_sq: it.from_sq, to_sq: it.to_sq,
                                  kind: it.move_kind};
      end
      CMD_READ: begin
        r.out_piece    = move_list_m[it.index].piece;
        r.out_captured = move_list_m[it.index].captured;
        r.out_from     = move_list_m[it.index].from_sq;
        r.out_to       = move_list_m[it.index].to_sq;
        r.out_kind     = move_list_m[it.index].kind;
      end
      CMD_SAVE: begin
        killer_m[it.ply].from_sq = move_list_m[it.index].from_sq;
        killer_m[it.ply].to_sq   = move_list_m[it.index].to_sq;
      end
      default: begin
        stop = (it.segment_end > LIST_ENTRIES) ? LIST_ENTRIES : int'(it.segment_end);
        pos  = int'(it.start_req);
        while (pos < stop &&
               (move_list_m[pos].from_sq != killer_m[it.ply].from_sq ||
                move_list_m[pos].to_sq != killer_m[it.ply].to_sq)) begin
          pos++;
        end
        if (pos < stop) begin
          held = move_list_m[pos];
          for (k = pos; k > int'(it.start_req); k--) begin
            move_list_m[k] = move_list_m[k-1];
          end
          move_list_m[it.start_req] = held;
          r.found       = 1'b1;
          r.found_index = pos[7:0];
        end
      end
    endcase
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  // from/to pairs mostly from a small pool so killers show up in segments
  function automatic kpair_t random_pair();
    kpair_t p;
    if ($urandom_range(99) < 70) begin
      p = pair_pool[$urandom_range(0, 5)];
    end else begin
      p.from_sq = SQ_W'($urandom_range(0, 127));
      p.to_sq   = SQ_W'($urandom_range(0, 127));
    end
    return p;
  endfunction

  function automatic logic [PLY_W-1:0] random_ply();
    if ($urandom_range(99) < 80) return PLY_W'($urandom_range(0, 7));
    return PLY_W'($urandom_range(0, PLY_SLOTS - 1));
  endfunction

  task automatic send_item(input item_t it, input bit no_gap);
    int gap;
    res_t r;
    if ($urandom_range(29) == 0) tx_calm = !tx_calm;
    gap = (no_gap || tx_calm) ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= it.cmd;
    in_if.index       <= it.index;
    in_if.ply         <= it.ply;
    in_if.start_req   <= it.start_req;
    in_if.segment_end <= it.segment_end;
    in_if.piece       <= it.piece;
    in_if.captured    <= it.captured;
    in_if.from_sq     <= it.from_sq;
    in_if.to_sq       <= it.to_sq;
    in_if.move_kind   <= it.move_kind;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = apply_command(it);
    pending_results.push_back(r);
    n_per_cmd[it.cmd]++;
    if (r.found) n_hits++;
  endtask

  task automatic issue_write(input int idx, input int pc, input int cap,
                             input int fsq, input int tsq, input int kd);
    item_t it;
    it           = random_item();
    it.cmd       = CMD_WRITE;
    it.index     = IDX_W'(idx);
    it.piece     = PC_W'(pc);
    it.captured  = PC_W'(cap);
    it.from_sq   = SQ_W'(fsq);
    it.to_sq     = SQ_W'(tsq);
    it.move_kind = KIND_W'(kd);
    send_item(it, 1'b0);
  endtask

  task automatic issue_read(input int idx);
    item_t it;
    it       = random_item();
    it.cmd   = CMD_READ;
    it.index = IDX_W'(idx);
    send_item(it, 1'b0);
  endtask

  task automatic issue_save(input int idx, input int ply);
    item_t it;
    it       = random_item();
    it.cmd   = CMD_SAVE;
    it.index = IDX_W'(idx);
    it.ply   = PLY_W'(ply);
    send_item(it, 1'b0);
  endtask

  task automatic issue_promote(input int ply, input int first, input int stop);
    item_t it;
    it             = random_item();
    it.cmd         = CMD_INSERT;
    it.ply         = PLY_W'(ply);
    it.start_req   = IDX_W'(first);
    it.segment_end = SEG_W'(stop);
    send_item(it, 1'b0);
  endtask

  task automatic test_entry_extremes();
    issue_write(0, 7, 7, 127, 127, 7);
    issue_write(1, 0, 0, 0, 0, 0);
    issue_write(2, 1, 0, 'h12, 'h34, 4);
    issue_write(3, 6, 5, 'h55, 'h66, 5);
    issue_write(255, 5, 3, 'h77, 'h70, 3);
    issue_write(254, 2, 1, 'h01, 'h02, 2);
    issue_read(0);
    issue_read(255);
  endtask

  task automatic test_killer_cases();
    // killer table comes out of reset as zeros, entry 1 holds a zero pair
    issue_promote(5, 0, 4);
    issue_save(3, 127);
    issue_promote(127, 0, 4);
    // empty segments
    issue_promote(127, 2, 2);
    issue_promote(127, 3, 1);
    // killer absent from a non-empty segment
    issue_promote(127, 1, 4);
    // end clipped to the list size, hit right at the start
    issue_save(254, 0);
    issue_promote(0, 254, 511);
    issue_promote(0, 255, 256);
    issue_save(255, 0);
    issue_promote(0, 255, 300);
    issue_promote(127, 0, 3);
    issue_promote(64, 0, 4);
    issue_read(1);
    issue_read(3);
  endtask

  task automatic fill_move_list();
    kpair_t p;
    for (int n = 0; n < 6; n++) begin
      pair_pool[n].from_sq = SQ_W'($urandom_range(0, 127));
      pair_pool[n].to_sq   = SQ_W'($urandom_range(0, 127));
    end
    for (int idx = 0; idx < LIST_ENTRIES; idx++) begin
      p = random_pair();
      issue_write(idx, $urandom_range(0, 7), $urandom_range(0, 7),
                  p.from_sq, p.to_sq, $urandom_range(0, 7));
    end
  endtask

  task automatic test_random_commands();
    item_t  it;
    kpair_t p;
    int     r;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      it = random_item();
      r  = $urandom_range(99);
      if (r < 22) begin
        it.cmd     = CMD_WRITE;
        p          = random_pair();
        it.from_sq = p.from_sq;
        it.to_sq   = p.to_sq;
      end else if (r < 40) begin
        it.cmd = CMD_READ;
      end else if (r < 58) begin
        it.cmd = CMD_SAVE;
        it.ply = random_ply();
      end else begin
        it.cmd       = CMD_INSERT;
        it.ply       = random_ply();
        it.start_req = IDX_W'($urandom_range(0, LIST_ENTRIES - 1));
        r = $urandom_range(99);
        if (r < 70) it.segment_end = SEG_W'(it.start_req + $urandom_range(0, 24));
        else if (r < 88) it.segment_end = SEG_W'(it.start_req + $urandom_range(25, 90));
        else it.segment_end = SEG_W'($urandom_range(0, 511));
      end
      send_item(it, 1'b0);
    end
  endtask

  // output side holds off while reads and writes keep coming back to back
  task automatic test_backpressure();
    item_t it;
    in_if.valid  <= 1'b0;
    hold_request = HOLD_CYCLES;
    wait (rx_holding);
    @(posedge clk_i);
    for (int n = 0; n < PRESSURE_ITEMS; n++) begin
      it     = random_item();
      it.cmd = (n % 2 == 0) ? CMD_READ : CMD_WRITE;
      send_item(it, 1'b1);
    end
  endtask

  initial begin
    for (int n = 0; n < PLY_SLOTS; n++) killer_m[n] = '0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.cmd         <= CMD_WRITE;
    in_if.index       <= '0;
    in_if.ply         <= '0;
    in_if.start_req   <= '0;
    in_if.segment_end <= '0;
    in_if.piece       <= '0;
    in_if.captured    <= '0;
    in_if.from_sq     <= '0;
    in_if.to_sq       <= '0;
    in_if.move_kind   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_entry_extremes();
    test_killer_cases();
    fill_move_list();
    test_random_commands();
    test_backpressure();
    test_random_commands();

    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d writes, %0d reads, %0d killer saves, %0d inserts (%0d hits)",
             n_per_cmd[CMD_WRITE], n_per_cmd[CMD_READ], n_per_cmd[CMD_SAVE],
             n_per_cmd[CMD_INSERT], n_hits);
    $display("including a %0d-cycle output hold with the input stalled, %0d mismatches",
             HOLD_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // output ready: random stalls, calm stretches, and one long hold on request
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        n            = hold_request;
        hold_request = 0;
        rx_holding   = 1'b1;
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        rx_holding = 1'b0;
      end else begin
        if ($urandom_range(39) == 0) rx_calm = !rx_calm;
        n = rx_calm ? 0 : pick_gap();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic compare_field(input string tag, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("%0t: unexpected transaction, expected none, actual found=%0b idx=%0h",
                   $time, out_if.found, out_if.found_index);
        end
      end else begin
        want = pending_results.pop_front();
        compare_field("found", 8'(want.found), 8'(out_if.found));
        compare_field("found_index", want.found_index, out_if.found_index);
        compare_field("out_piece", 8'(want.out_piece), 8'(out_if.out_piece));
        compare_field("out_captured", 8'(want.out_captured), 8'(out_if.out_captured));
        compare_field("out_from", 8'(want.out_from), 8'(out_if.out_from));
        compare_field("out_to", 8'(want.out_to), 8'(out_if.out_to));
        compare_field("out_kind", 8'(want.out_kind), 8'(out_if.out_kind));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

endmodule
